@@ hdl/ebau_pkg.sv @@
package ebau_pkg;

  localparam int unsigned ArchiveDepthDefault = 64;

  localparam int unsigned ValW   = 32;
  localparam int unsigned EpsW   = 31;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned RemW   = 6;
  localparam int unsigned OutcW  = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [EpsW-1:0] EpsReset = 31'd65536;

  localparam logic [CfgIdxW-1:0] REG_EPS_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_EPS_SECOND = 1'b1;

  localparam logic [OutcW-1:0] OUT_REJECT    = 3'd0;
  localparam logic [OutcW-1:0] OUT_REPL_DOM  = 3'd1;
  localparam logic [OutcW-1:0] OUT_REPL_SAME = 3'd2;
  localparam logic [OutcW-1:0] OUT_SAME_KEPT = 3'd3;
  localparam logic [OutcW-1:0] OUT_APPEND    = 3'd4;
  localparam logic [OutcW-1:0] OUT_FULL      = 3'd5;
  localparam logic [OutcW-1:0] OUT_READ      = 3'd6;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic             load;
    logic             rd_slot;
    logic             rd_idx;
    logic             div_start;
    logic             div_sel;
    logic             div_latch;
    logic             wr_cand_idx;
    logic             wr_cand_cnt;
    logic             wr_move;
    logic             idx_inc;
    logic             wptr_set;
    logic             wptr_inc;
    logic             rem_inc;
    logic             cnt_from_wptr;
    logic             cnt_inc;
    logic [1:0]       gap_sel;
    logic             gap_mul;
    logic             gap_sub;
    logic             gap_sq;
    logic             gap_acc;
    logic             res_load;
    logic [OutcW-1:0] outcome;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_end;
    logic has_room;
    logic ent_dom;
    logic cand_dom;
    logic box_match;
    logic pareto;
    logic closer;
  } sts_t;

endpackage

@@ hdl/epsilon_box_archive_update.sv @@
// Ordered archive of two-objective Q16.16 points under epsilon-box dominance.
// Each input word either inserts a candidate or reads one entry, and gives
// exactly one result word. An insert computes the two box divisions on one
// shared bit-serial divider, then walks or compacts the archive one entry at
// a time, since the entry memory has a single read port; a same-box decision
// runs on one shared multiplier. A new word is taken while the previous
// result still waits on the output side.
module epsilon_box_archive_update #(
  parameter int unsigned ARCHIVE_DEPTH = ebau_pkg::ArchiveDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ebau_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ebau_pkg::EpsW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // value_first [31:0], value_second [63:32], read_slot [69:64].
  input  logic [71:0]                  s_axis_tdata,
  // action [0].
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // entry_count [6:0], removed_count [12:7], entry_first [44:13],
  // entry_second [76:45], read_hit [77].
  output logic [79:0]                  m_axis_tdata,
  // outcome [2:0].
  output logic [2:0]                   m_axis_tuser
);
  import ebau_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [CountW-1:0]      res_count;
  logic [RemW-1:0]        res_removed;
  logic signed [ValW-1:0] res_first, res_second;
  logic                   res_hit;

  ebau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .act_i     (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ebau_dpath #(
    .ARCHIVE_DEPTH (ARCHIVE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_first_i    (s_axis_tdata[31:0]),
    .in_second_i   (s_axis_tdata[63:32]),
    .in_slot_i     (s_axis_tdata[69:64]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_outcome_o (m_axis_tuser),
    .res_count_o   (res_count),
    .res_removed_o (res_removed),
    .res_first_o   (res_first),
    .res_second_o  (res_second),
    .res_hit_o     (res_hit)
  );

  assign m_axis_tdata = {2'b00, res_hit, res_second, res_first, res_removed, res_count};

endmodule

@@ hdl/ebau_div.sv @@
module ebau_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ebau_pkg::ValW-1:0] dividend_i,
  input  logic        [ebau_pkg::EpsW-1:0] divisor_i,
  output logic                             done_o,
  output logic signed [ebau_pkg::ValW-1:0] quot_o
);
  import ebau_pkg::*;

  logic [ValW-1:0] q_q, q_d;
  logic [EpsW-1:0] rem_q, rem_d;
  logic [EpsW-1:0] dvs_q;
  logic            neg_q;
  logic [5:0]      cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [ValW-1:0] trial;
  logic [ValW:0]   fix;

  always_comb begin
    trial = {rem_q, q_q[ValW-1]};
    q_d   = q_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (cnt_q != 6'd0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = EpsW'(trial - {1'b0, dvs_q});
        q_d   = {q_q[ValW-2:0], 1'b1};
      end else begin
        rem_d = trial[EpsW-1:0];
        q_d   = {q_q[ValW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 6'(ValW);
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i[ValW-1] ? ValW'(-(33'(dividend_i))) : dividend_i;
      rem_q <= '0;
      dvs_q <= (divisor_i == '0) ? EpsW'(1) : divisor_i;
      neg_q <= dividend_i[ValW-1];
    end else begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign fix    = {1'b0, q_q} + {{ValW{1'b0}}, (rem_q != '0)};
  assign quot_o = neg_q ? ValW'(-fix) : q_q;
  assign done_o = done_q;

endmodule

@@ hdl/ebau_dpath.sv @@
module ebau_dpath #(
  parameter int unsigned ARCHIVE_DEPTH = ebau_pkg::ArchiveDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ebau_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ebau_pkg::EpsW-1:0]           cfg_wdata_i,
  input  logic signed [ebau_pkg::ValW-1:0]    in_first_i,
  input  logic signed [ebau_pkg::ValW-1:0]    in_second_i,
  input  logic [ebau_pkg::SlotW-1:0]          in_slot_i,
  input  ebau_pkg::cmd_t                      cmd_i,
  output ebau_pkg::sts_t                      sts_o,
  output logic [ebau_pkg::OutcW-1:0]          res_outcome_o,
  output logic [ebau_pkg::CountW-1:0]         res_count_o,
  output logic [ebau_pkg::RemW-1:0]           res_removed_o,
  output logic signed [ebau_pkg::ValW-1:0]    res_first_o,
  output logic signed [ebau_pkg::ValW-1:0]    res_second_o,
  output logic                                res_hit_o
);
  import ebau_pkg::*;

  localparam int unsigned AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ARCHIVE_DEPTH + 1);
  localparam int unsigned EW = 4 * ValW;

  logic [EpsW-1:0] eps1_q, eps2_q, eps1, eps2;
  logic signed [ValW-1:0] val1_q, val2_q, box1_q, box2_q;
  logic [SlotW-1:0] slot_q;
  logic [CW-1:0] cnt_q, idx_q, wptr_q, rem_q;

  logic [EW-1:0] mem [ARCHIVE_DEPTH];
  logic [EW-1:0] rdata_q;
  logic [EW-1:0] cand;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic signed [ValW-1:0] r_pt1, r_pt2, r_bx1, r_bx2;
  logic                   div_done;
  logic signed [ValW-1:0] div_quot;

  logic signed [63:0] prod_q;
  logic [ValW-1:0]    mag_q;
  logic [63:0]        d1_q, d2_q;
  logic signed [ValW-1:0] g_val, g_box;
  logic [EpsW-1:0]    g_eps;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] diff;
  logic [63:0]        absd;
  logic               hit;

  function automatic logic dom(input logic signed [ValW-1:0] a1, input logic signed [ValW-1:0] a2,
                               input logic signed [ValW-1:0] b1, input logic signed [ValW-1:0] b2);
    return (a1 <= b1) && (a2 <= b2) && ((a1 < b1) || (a2 < b2));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps1_q <= EpsReset;
      eps2_q <= EpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EPS_FIRST:  eps1_q <= cfg_wdata_i;
        REG_EPS_SECOND: eps2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eps1 = (eps1_q == '0) ? EpsW'(1) : eps1_q;
  assign eps2 = (eps2_q == '0) ? EpsW'(1) : eps2_q;

  ebau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel ? val2_q : val1_q),
    .divisor_i  (cmd_i.div_sel ? eps2 : eps1),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val1_q <= in_first_i;
      val2_q <= in_second_i;
      slot_q <= in_slot_i;
    end
    if (cmd_i.div_latch) begin
      if (cmd_i.div_sel) begin
        box2_q <= div_quot;
      end else begin
        box1_q <= div_quot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      wptr_q <= '0;
      rem_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        rem_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.wptr_set) begin
        wptr_q <= idx_q + CW'(1);
      end else if (cmd_i.wptr_inc) begin
        wptr_q <= wptr_q + CW'(1);
      end
      if (cmd_i.rem_inc) begin
        rem_q <= rem_q + CW'(1);
      end
      if (cmd_i.cnt_from_wptr) begin
        cnt_q <= wptr_q;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  assign cand = {box2_q, box1_q, val2_q, val1_q};

  always_comb begin
    we    = cmd_i.wr_cand_idx | cmd_i.wr_cand_cnt | cmd_i.wr_move;
    waddr = idx_q[AW-1:0];
    wdata = cand;
    if (cmd_i.wr_cand_cnt) begin
      waddr = cnt_q[AW-1:0];
    end else if (cmd_i.wr_move) begin
      waddr = wptr_q[AW-1:0];
      wdata = rdata_q;
    end
    raddr = cmd_i.rd_slot ? AW'(slot_q) : idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_slot || cmd_i.rd_idx) begin
      rdata_q <= mem[raddr];
    end
  end

  assign r_pt1 = rdata_q[ValW-1:0];
  assign r_pt2 = rdata_q[2*ValW-1:ValW];
  assign r_bx1 = rdata_q[3*ValW-1:2*ValW];
  assign r_bx2 = rdata_q[4*ValW-1:3*ValW];

  always_comb begin
    g_eps = cmd_i.gap_sel[0] ? eps2 : eps1;
    if (cmd_i.gap_sel[1]) begin
      g_val = cmd_i.gap_sel[0] ? r_pt2 : r_pt1;
      g_box = cmd_i.gap_sel[0] ? r_bx2 : r_bx1;
    end else begin
      g_val = cmd_i.gap_sel[0] ? val2_q : val1_q;
      g_box = cmd_i.gap_sel[0] ? box2_q : box1_q;
    end
    if (cmd_i.gap_sq) begin
      mul_a = $signed({1'b0, mag_q});
      mul_b = $signed({1'b0, mag_q});
    end else begin
      mul_a = 33'(g_box);
      mul_b = $signed({2'b00, g_eps});
    end
    diff = 64'(g_val) - prod_q;
    absd = diff[63] ? 64'(-diff) : 64'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_mul || cmd_i.gap_sq) begin
      prod_q <= 64'(mul_a * mul_b);
    end
    if (cmd_i.gap_sub) begin
      mag_q <= (absd > 64'h8000_0000) ? 32'h8000_0000 : absd[ValW-1:0];
    end
    if (cmd_i.load) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.gap_acc) begin
      if (cmd_i.gap_sel[1]) begin
        d2_q <= d2_q + prod_q;
      end else begin
        d1_q <= d1_q + prod_q;
      end
    end
  end

  assign hit = (32'(slot_q) < 32'(cnt_q));

  always_comb begin
    sts_o.div_done  = div_done;
    sts_o.idx_end   = (idx_q >= cnt_q);
    sts_o.has_room  = (32'(cnt_q) < ARCHIVE_DEPTH);
    sts_o.ent_dom   = dom(r_bx1, r_bx2, box1_q, box2_q);
    sts_o.cand_dom  = dom(box1_q, box2_q, r_bx1, r_bx2);
    sts_o.box_match = (r_bx1 == box1_q) && (r_bx2 == box2_q);
    sts_o.pareto    = dom(val1_q, val2_q, r_pt1, r_pt2);
    sts_o.closer    = (d1_q < d2_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_outcome_o <= cmd_i.outcome;
      res_count_o   <= (32'(cnt_q) > 127) ? CountW'(127) : CountW'(cnt_q);
      res_removed_o <= (32'(rem_q) > 63) ? RemW'(63) : RemW'(rem_q);
      if (cmd_i.outcome == OUT_READ && hit) begin
        res_first_o  <= r_pt1;
        res_second_o <= r_pt2;
      end else begin
        res_first_o  <= '0;
        res_second_o <= '0;
      end
      res_hit_o <= (cmd_i.outcome == OUT_READ) && hit;
    end
  end

endmodule

@@ hdl/ebau_ctrl.sv @@
module ebau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           act_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  ebau_pkg::sts_t sts_i,
  output ebau_pkg::cmd_t cmd_o
);
  import ebau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_DIV2  = 4'd4;
  localparam logic [3:0] S_WAIT2 = 4'd5;
  localparam logic [3:0] S_WISS  = 4'd6;
  localparam logic [3:0] S_WEVL  = 4'd7;
  localparam logic [3:0] S_CISS  = 4'd8;
  localparam logic [3:0] S_CEVL  = 4'd9;
  localparam logic [3:0] S_GMUL  = 4'd10;
  localparam logic [3:0] S_GSUB  = 4'd11;
  localparam logic [3:0] S_GSQ   = 4'd12;
  localparam logic [3:0] S_GACC  = 4'd13;
  localparam logic [3:0] S_SDEC  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]       state_q, state_d;
  logic [OutcW-1:0] outc_q, outc_d;
  logic [1:0]       gap_q, gap_d;
  logic             mval_q, mval_d;

  always_comb begin
    state_d = state_q;
    outc_d  = outc_q;
    gap_d   = gap_q;
    mval_d  = mval_q & ~m_ready_i;
    cmd_o   = '0;
    cmd_o.gap_sel = gap_q;
    cmd_o.outcome = outc_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (act_i == ACT_READ) begin
            outc_d  = OUT_READ;
            state_d = S_RD;
          end else begin
            state_d = S_DIV1;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_slot = 1'b1;
        state_d = S_FIN;
      end
      S_DIV1: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT1;
      end
      S_WAIT1: begin
        if (sts_i.div_done) begin
          cmd_o.div_latch = 1'b1;
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT2;
      end
      S_WAIT2: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_latch = 1'b1;
          state_d = S_WISS;
        end
      end
      S_WISS: begin
        if (sts_i.idx_end) begin
          if (sts_i.has_room) begin
            cmd_o.wr_cand_cnt = 1'b1;
            cmd_o.cnt_inc     = 1'b1;
            outc_d = OUT_APPEND;
          end else begin
            outc_d = OUT_FULL;
          end
          state_d = S_FIN;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d = S_WEVL;
        end
      end
      S_WEVL: begin
        if (sts_i.ent_dom) begin
          outc_d  = OUT_REJECT;
          state_d = S_FIN;
        end else if (sts_i.cand_dom) begin
          cmd_o.wr_cand_idx = 1'b1;
          cmd_o.wptr_set    = 1'b1;
          cmd_o.idx_inc     = 1'b1;
          state_d = S_CISS;
        end else if (sts_i.box_match) begin
          if (sts_i.pareto) begin
            cmd_o.wr_cand_idx = 1'b1;
            outc_d  = OUT_REPL_SAME;
            state_d = S_FIN;
          end else begin
            gap_d   = 2'd0;
            state_d = S_GMUL;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_WISS;
        end
      end
      S_CISS: begin
        if (sts_i.idx_end) begin
          cmd_o.cnt_from_wptr = 1'b1;
          outc_d  = OUT_REPL_DOM;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d = S_CEVL;
        end
      end
      S_CEVL: begin
        if (sts_i.cand_dom) begin
          cmd_o.rem_inc = 1'b1;
        end else begin
          cmd_o.wr_move  = 1'b1;
          cmd_o.wptr_inc = 1'b1;
        end
        cmd_o.idx_inc = 1'b1;
        state_d = S_CISS;
      end
      S_GMUL: begin
        cmd_o.gap_mul = 1'b1;
        state_d = S_GSUB;
      end
      S_GSUB: begin
        cmd_o.gap_sub = 1'b1;
        state_d = S_GSQ;
      end
      S_GSQ: begin
        cmd_o.gap_sq = 1'b1;
        state_d = S_GACC;
      end
      S_GACC: begin
        cmd_o.gap_acc = 1'b1;
        gap_d = gap_q + 2'd1;
        state_d = (gap_q == 2'd3) ? S_SDEC : S_GMUL;
      end
      S_SDEC: begin
        if (sts_i.closer) begin
          cmd_o.wr_cand_idx = 1'b1;
          outc_d = OUT_REPL_SAME;
        end else begin
          outc_d = OUT_SAME_KEPT;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!mval_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          mval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outc_q  <= OUT_REJECT;
      gap_q   <= 2'd0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outc_q  <= outc_d;
      gap_q   <= gap_d;
      mval_q  <= mval_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = mval_q;

endmodule

@@ bench/ebau_checker.sv @@
module ebau_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ebau_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ebau_pkg::EpsW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [71:0]                  s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [79:0]                  m_axis_tdata,
  input  logic [2:0]                   m_axis_tuser,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ebau_pkg::*;

  localparam int Depth = 64;

  typedef struct packed {
    logic [OutcW-1:0]  outcome;
    logic [CountW-1:0] count;
    logic [RemW-1:0]   removed;
    logic [ValW-1:0]   first;
    logic [ValW-1:0]   second;
    logic              hit;
  } archive_result_t;

  archive_result_t result_q[$];
  longint points[Depth][2];
  longint boxes[Depth][2];
  int unsigned fill;
  logic [EpsW-1:0] eps_a, eps_b;
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic bit box_beats(longint a0, longint a1, longint b0, longint b1);
    if (a0 > b0 || a1 > b1) begin
      return 1'b0;
    end
    return (a0 < b0) || (a1 < b1);
  endfunction

  function automatic longint floor_quot(longint v, longint e);
    longint q;
    q = v / e;
    if ((v % e) != 0 && v < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint unsigned corner_gap(longint v, longint b, longint e);
    longint d;
    longint unsigned m;
    d = v - b * e;
    m = (d < 0) ? longint'(-d) : d;
    if (m > 64'h8000_0000) begin
      m = 64'h8000_0000;
    end
    return m * m;
  endfunction

  function automatic archive_result_t update_archive(logic act, logic [31:0] raw_a,
                                                     logic [31:0] raw_b, logic [5:0] slot);
    archive_result_t r;
    longint e[2], v[2], b[2];
    int unsigned n, w, removed;
    int same;
    bit done, le, lt, take;
    longint unsigned d_new, d_old;
    r = '0;
    n = fill;
    removed = 0;
    same = -1;
    done = 1'b0;
    if (act == ACT_READ) begin
      r.outcome = OUT_READ;
      if (slot < n) begin
        r.hit    = 1'b1;
        r.first  = points[slot][0][31:0];
        r.second = points[slot][1][31:0];
      end
    end else begin
      e[0] = (eps_a == 0) ? 1 : longint'(eps_a);
      e[1] = (eps_b == 0) ? 1 : longint'(eps_b);
      v[0] = longint'(signed'(raw_a));
      v[1] = longint'(signed'(raw_b));
      b[0] = floor_quot(v[0], e[0]);
      b[1] = floor_quot(v[1], e[1]);
      for (int i = 0; i < n && !done && same < 0; i++) begin
        if (box_beats(boxes[i][0], boxes[i][1], b[0], b[1])) begin
          r.outcome = OUT_REJECT;
          done = 1'b1;
        end else if (box_beats(b[0], b[1], boxes[i][0], boxes[i][1])) begin
          w = i + 1;
          points[i] = v;
          boxes[i]  = b;
          for (int j = i + 1; j < n; j++) begin
            if (box_beats(b[0], b[1], boxes[j][0], boxes[j][1])) begin
              removed++;
            end else begin
              points[w] = points[j];
              boxes[w]  = boxes[j];
              w++;
            end
          end
          n = w;
          r.outcome = OUT_REPL_DOM;
          done = 1'b1;
        end else if (boxes[i][0] == b[0] && boxes[i][1] == b[1]) begin
          same = i;
        end
      end
      if (!done) begin
        if (same >= 0) begin
          le = (v[0] <= points[same][0]) && (v[1] <= points[same][1]);
          lt = (v[0] < points[same][0]) || (v[1] < points[same][1]);
          take = le && lt;
          if (!take) begin
            d_new = corner_gap(v[0], b[0], e[0]) + corner_gap(v[1], b[1], e[1]);
            d_old = corner_gap(points[same][0], boxes[same][0], e[0]) +
                    corner_gap(points[same][1], boxes[same][1], e[1]);
            take = d_new < d_old;
          end
          if (take) begin
            points[same] = v;
            boxes[same]  = b;
            r.outcome = OUT_REPL_SAME;
          end else begin
            r.outcome = OUT_SAME_KEPT;
          end
        end else if (n < Depth) begin
          points[n] = v;
          boxes[n]  = b;
          n++;
          r.outcome = OUT_APPEND;
        end else begin
          r.outcome = OUT_FULL;
        end
      end
      fill = n;
    end
    r.count   = CountW'(fill);
    r.removed = (removed > 63) ? RemW'(63) : RemW'(removed);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    archive_result_t want;
    if (!rst_ni) begin
      fill  = 0;
      eps_a = EpsReset;
      eps_b = EpsReset;
      fails = 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_EPS_FIRST) begin
          eps_a = cfg_wdata_i;
        end else if (cfg_idx_i == REG_EPS_SECOND) begin
          eps_b = cfg_wdata_i;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = result_q.pop_front();
          if (m_axis_tuser !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[6:0] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_axis_tdata[6:0]);
            fails++;
          end
          if (m_axis_tdata[12:7] !== want.removed) begin
            $error("removed_count: expected %0d, got %0d", want.removed,
                   m_axis_tdata[12:7]);
            fails++;
          end
          if (m_axis_tdata[44:13] !== want.first) begin
            $error("entry_first: expected %h, got %h", want.first, m_axis_tdata[44:13]);
            fails++;
          end
          if (m_axis_tdata[76:45] !== want.second) begin
            $error("entry_second: expected %h, got %h", want.second,
                   m_axis_tdata[76:45]);
            fails++;
          end
          if (m_axis_tdata[77] !== want.hit) begin
            $error("read_hit: expected %0d, got %0d", want.hit, m_axis_tdata[77]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.insert(result_q.size(),
                        update_archive(s_axis_tuser, s_axis_tdata[31:0],
                                       s_axis_tdata[63:32], s_axis_tdata[69:64]));
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ebau_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [EpsW-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  int                 fail_count;
  int                 pending;
  int                 stall_req = 0;
  bit                 steady = 1'b0;
  int                 inserts = 0;
  int                 reads = 0;
  int                 settings = 0;
  longint             eps_x = 65536;
  longint             eps_y = 65536;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  epsilon_box_archive_update dut (.*);

  ebau_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(15, 60);
  endfunction

  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (stall_req > 0) begin
        hold = stall_req;
        stall_req = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= (idle_len() == 0);
    end
  end

  task automatic send_word(logic act, logic [31:0] va, logic [31:0] vb, logic [5:0] slot);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, slot, vb, va};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_READ) reads++; else inserts++;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_set(logic [EpsW-1:0] ea, logic [EpsW-1:0] eb);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_EPS_FIRST;
    cfg_wdata_i <= ea;
    @(posedge clk_i);
    cfg_idx_i <= REG_EPS_SECOND;
    cfg_wdata_i <= eb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eps_x = (ea == 0) ? 1 : ea;
    eps_y = (eb == 0) ? 1 : eb;
    settings++;
  endtask

  function automatic logic [31:0] fit32(longint v);
    if (v > 64'sd2147483647 || v < -64'sd2147483648) begin
      return $urandom;
    end
    return v[31:0];
  endfunction

  task automatic random_word();
    int kind, k, j;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, 70) - 35;
    j = $urandom_range(1, 3);
    if (kind < 20) begin
      send_word(ACT_READ, $urandom, $urandom, 6'($urandom_range(0, 63)));
    end else if (kind < 70) begin
      send_word(ACT_INSERT, fit32(k * eps_x + longint'($urandom_range(0, 1000)) % eps_x),
                fit32(-k * eps_y + longint'($urandom_range(0, 1000)) % eps_y),
                6'($urandom));
    end else if (kind < 85) begin
      send_word(ACT_INSERT, fit32((k - j) * eps_x), fit32((-k - j) * eps_y), 6'($urandom));
    end else begin
      send_word(ACT_INSERT, $urandom, $urandom, 6'($urandom));
    end
  endtask

  initial begin
    logic [EpsW-1:0] ea, eb;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_word(ACT_INSERT, 32'h0000_8000, 32'h0000_8000, 6'd0);
    send_word(ACT_INSERT, 32'h0000_4000, 32'h0000_9000, 6'd0);
    send_word(ACT_INSERT, 32'h0000_4000, 32'h0000_9000, 6'd0);
    send_word(ACT_INSERT, 32'h0000_3000, 32'h0000_8000, 6'd0);
    send_word(ACT_INSERT, 32'h0002_0000, 32'h0003_0000, 6'd0);
    send_word(ACT_INSERT, 32'hFFFF_0000, 32'h0005_0000, 6'd0);
    send_word(ACT_INSERT, 32'h0005_0000, 32'hFFFF_0000, 6'd0);
    send_word(ACT_READ, 32'h0, 32'h0, 6'd2);
    send_word(ACT_INSERT, 32'hFFFE_0000, 32'hFFFE_0000, 6'd0);
    send_word(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_word(ACT_READ, 32'h0, 32'h0, 6'd1);
    send_word(ACT_READ, 32'h0, 32'h0, 6'd63);
    send_word(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0);
    send_word(ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
    send_word(ACT_READ, 32'h0, 32'h0, 6'd1);
    drain_and_set(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(ACT_INSERT, 32'h8000_0000, 32'h8000_0000, 6'd0);
    send_word(ACT_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0);
    drain_and_set(31'd0, 31'd0);
    send_word(ACT_INSERT, 32'h8000_0001, 32'h8000_0001, 6'd0);
    send_word(ACT_INSERT, 32'h8000_0000, 32'h8000_0001, 6'd0);
    send_word(ACT_READ, 32'h0, 32'h0, 6'd0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin ea = 31'd65536; eb = 31'd65536; end
        1: begin ea = 31'd1; eb = 31'd1; end
        2: begin ea = 31'h7FFF_FFFF; eb = 31'd1; end
        3: begin ea = 31'd300000; eb = 31'd40000; end
        4: begin ea = 31'h7FFF_FFFF; eb = 31'h7FFF_FFFF; end
        default: begin
          ea = EpsW'($urandom_range(1, 31'h7FFF_FFFF));
          eb = EpsW'($urandom_range(1, 1 << 20));
        end
      endcase
      drain_and_set(ea, eb);
      steady = (phase == 3);
      for (int n = 0; n < 90; n++) begin
        if (phase == 0 && n == 40) begin
          stall_req = 400;
        end
        random_word();
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d inserts and %0d reads across %0d box-size settings.",
             inserts, reads, settings);
    if (fail_count == 0 && pending == 0) begin
      $display("[epsilon_box_archive_update] OK");
    end else begin
      $display("[epsilon_box_archive_update] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[epsilon_box_archive_update] ERROR");
    $finish;
  end

endmodule
